// ===== sv/tdma_uplink_slot_owner_defines.svh =====
// ----------------------------------------------------------------------------
// Uplink slot owner - assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef TDMA_UPLINK_SLOT_OWNER_DEFINES_SVH
`define TDMA_UPLINK_SLOT_OWNER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TUSO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TUSO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/tuso_pkg.sv =====
// ----------------------------------------------------------------------------
// Uplink slot owner - shared package
// Operation codes, register indexes, configuration and result types.
// ----------------------------------------------------------------------------
package tuso_pkg;

	localparam logic OP_ALIGN = 1'b0;
	localparam logic OP_TAKE  = 1'b1;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SUPERFRAME_DURATION = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_DURATION       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UPLINKS_PER_SF      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_COUNT          = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UPLINK_TILE_MASK    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_SLOT_DURATION  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NODES_COUNT         = 3'd6;

	localparam int CFG_DATA_W = 32;
	localparam int TIME_W     = 63;
	localparam int NODE_W     = 8;

	typedef struct packed {
		logic [31:0] superframe_duration;
		logic [31:0] tile_duration;
		logic [5:0]  uplinks_per_superframe;
		logic [5:0]  tile_count;
		logic [31:0] uplink_tile_mask;
		logic [31:0] data_slot_duration;
		logic [7:0]  nodes_count;
	} cfg_t;

	typedef struct packed {
		logic              done;
		logic [NODE_W-1:0] owner;
	} res_t;

	// Owner span M = max(nodes_count, 2) - 1.
	function automatic logic [NODE_W-1:0] owner_span(input logic [NODE_W-1:0] nodes);
		logic [NODE_W-1:0] span;
		span = (nodes < 8'd2) ? 8'd1 : (nodes - 8'd1);
		return span;
	endfunction

	// Six-bit value modulo m (m >= 1), one bit per step.
	function automatic logic [NODE_W-1:0] mod_small(input logic [5:0] val,
			input logic [NODE_W-1:0] m);
		logic [NODE_W:0] r;
		r = '0;
		for (int i = 5; i >= 0; i--) begin
			r = {r[NODE_W-1:0], val[i]};
			if (r >= {1'b0, m}) begin
				r = r - {1'b0, m};
			end
		end
		return r[NODE_W-1:0];
	endfunction

endpackage

// ===== sv/tuso_core.sv =====
// ----------------------------------------------------------------------------
// Uplink slot owner - align engine
// Bit-serial 64/32 division and tile walk on one subtractor, then phase reduction.
// ----------------------------------------------------------------------------
module tuso_core #(
	parameter int MAX_TILES = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tuso_pkg::TIME_W-1:0] network_time,
	input  tuso_pkg::cfg_t              cfg,
	output tuso_pkg::res_t              res
);

	localparam int IDX_W = $clog2(MAX_TILES + 1) < 1 ? 1 : $clog2(MAX_TILES + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_WALK,
		ST_FIN
	} state_t;

	state_t                       state_q;
	logic [63:0]                  dvd_q;
	logic [31:0]                  rem_q;
	logic [31:0]                  sfd_q;
	logic [5:0]                   cnt_q;
	logic [IDX_W-1:0]             idx_q;
	logic [IDX_W-1:0]             tiles_q;
	logic [31:0]                  mask_q;
	logic [tuso_pkg::NODE_W-1:0]  m_q;
	logic [tuso_pkg::NODE_W-1:0]  upsm_q;
	logic [tuso_pkg::NODE_W-1:0]  acc_q;
	logic [tuso_pkg::NODE_W-1:0]  pm_q;
	tuso_pkg::res_t               res_q;

	logic [63:0]                  t_start;
	logic [tuso_pkg::NODE_W-1:0]  m_start;
	logic [IDX_W-1:0]             tiles_start;
	logic [32:0]                  op_a;
	logic [31:0]                  op_b;
	logic [33:0]                  diff;
	logic                         ge;
	logic [9:0]                   acc_s0;
	logic [9:0]                   acc_s1;
	logic [9:0]                   acc_s2;
	logic [tuso_pkg::NODE_W-1:0]  pm_inc;
	logic [8:0]                   phase_sum;
	logic [tuso_pkg::NODE_W-1:0]  phase;

	// Time plus half a data slot; fits 64 bits for any 63-bit time.
	assign t_start = {1'b0, network_time} + {32'd0, 1'b0, cfg.data_slot_duration[31:1]};
	assign m_start = tuso_pkg::owner_span(cfg.nodes_count);

	always_comb begin
		if (int'(cfg.tile_count) > MAX_TILES) begin
			tiles_start = IDX_W'(MAX_TILES);
		end else begin
			tiles_start = IDX_W'(cfg.tile_count);
		end
	end

	// Shared compare/subtract unit.
	always_comb begin
		if (state_q == ST_DIV) begin
			op_a = {rem_q, dvd_q[63]};
			op_b = sfd_q;
		end else begin
			op_a = {1'b0, rem_q};
			op_b = cfg.tile_duration;
		end
		diff = {1'b0, op_a} - {2'b00, op_b};
		ge   = !diff[33];
	end

	// Running (quotient * upsm) mod m, quotient bits MSB first.
	always_comb begin
		acc_s0 = {1'b0, acc_q, 1'b0} + (ge ? {2'b00, upsm_q} : 10'd0);
		acc_s1 = (acc_s0 >= {2'b00, m_q}) ? acc_s0 - {2'b00, m_q} : acc_s0;
		acc_s2 = (acc_s1 >= {2'b00, m_q}) ? acc_s1 - {2'b00, m_q} : acc_s1;
	end

	assign pm_inc    = ((pm_q + 8'd1) == m_q) ? 8'd0 : (pm_q + 8'd1);
	assign phase_sum = {1'b0, acc_q} + {1'b0, pm_q};
	assign phase     = (phase_sum >= {1'b0, m_q}) ? 8'(phase_sum - {1'b0, m_q})
		: phase_sum[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_q   <= '0;
		end else begin
			res_q.done <= (state_q == ST_FIN);
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == 6'd63) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (idx_q == tiles_q || !ge) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					res_q.owner <= m_q - phase;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					dvd_q   <= t_start;
					rem_q   <= '0;
					sfd_q   <= (cfg.superframe_duration == 32'd0) ? 32'd1
						: cfg.superframe_duration;
					cnt_q   <= '0;
					idx_q   <= '0;
					tiles_q <= tiles_start;
					mask_q  <= cfg.uplink_tile_mask;
					m_q     <= m_start;
					upsm_q  <= tuso_pkg::mod_small(cfg.uplinks_per_superframe, m_start);
					acc_q   <= '0;
					pm_q    <= '0;
				end
			end
			ST_DIV: begin
				rem_q <= ge ? diff[31:0] : op_a[31:0];
				dvd_q <= {dvd_q[62:0], 1'b0};
				acc_q <= acc_s2[7:0];
				cnt_q <= cnt_q + 6'd1;
			end
			ST_WALK: begin
				if (idx_q != tiles_q && ge) begin
					rem_q  <= diff[31:0];
					mask_q <= {1'b0, mask_q[31:1]};
					idx_q  <= idx_q + IDX_W'(1);
					if (mask_q[0]) begin
						pm_q <= pm_inc;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

endmodule

// ===== sv/tdma_uplink_slot_owner.sv =====
// A take's result is registered into the output register, or into hold_q while
// the output stalls; an align runs the division, tile walk and ST_FIN first.
// One take item per cycle while the output is not stalled; no item is taken
// until an align result is loaded. The bit-serial 64/32 division and the tile
// walk share one 33-bit subtractor. arst_n clears config to defaults, owner to 0.
// ----------------------------------------------------------------------------
// Uplink slot owner tracker
// Aligns the uplink slot owner to a network time and steps it per uplink slot.
// ----------------------------------------------------------------------------
module tdma_uplink_slot_owner #(
	parameter int MAX_TILES = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input items
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [63:0]                          s_axis_tdata,   // [62:0] network_time
	input  logic                                 s_axis_tuser,   // [0] op
	// Result items
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [7:0]                           m_axis_tdata,   // [7:0] node
	// Configuration writes
	input  logic                                 cfg_we,
	input  logic [tuso_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tuso_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	// Top-level sequencer: idle, waiting for the align engine, or holding a
	// finished result until the output register frees up.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUSY,
		ST_HOLD
	} state_t;

	state_t                       state_q;
	tuso_pkg::cfg_t               cfg_q;
	logic [tuso_pkg::NODE_W-1:0]  owner_q;
	logic [tuso_pkg::NODE_W-1:0]  hold_q;
	logic                         m_valid_q;
	logic [tuso_pkg::NODE_W-1:0]  m_data_q;

	logic                         in_acc;
	logic                         out_free;
	logic                         out_load;
	logic                         align_start;
	logic [tuso_pkg::NODE_W-1:0]  span;
	logic [tuso_pkg::NODE_W-1:0]  take_next;
	tuso_pkg::res_t               core_res;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign align_start   = in_acc && (s_axis_tuser == tuso_pkg::OP_ALIGN);

	// Load the output register from a take, a finished align or a held result.
	assign out_load = out_free && ((in_acc && (s_axis_tuser == tuso_pkg::OP_TAKE))
		|| ((state_q == ST_BUSY) && core_res.done) || (state_q == ST_HOLD));

	// Step the owner down; wrap from 1 (or 0 after reset) to the span.
	assign span      = tuso_pkg::owner_span(cfg_q.nodes_count);
	assign take_next = (owner_q <= 8'd1) ? span : (owner_q - 8'd1);

	// Configuration registers; drop writes to unknown indexes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.superframe_duration    <= 32'd1;
			cfg_q.tile_duration          <= 32'd1;
			cfg_q.uplinks_per_superframe <= 6'd0;
			cfg_q.tile_count             <= 6'd1;
			cfg_q.uplink_tile_mask       <= 32'd0;
			cfg_q.data_slot_duration     <= 32'd0;
			cfg_q.nodes_count            <= 8'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tuso_pkg::REG_SUPERFRAME_DURATION: cfg_q.superframe_duration <= cfg_wdata;
				tuso_pkg::REG_TILE_DURATION:       cfg_q.tile_duration <= cfg_wdata;
				tuso_pkg::REG_UPLINKS_PER_SF:
					cfg_q.uplinks_per_superframe <= cfg_wdata[5:0];
				tuso_pkg::REG_TILE_COUNT:          cfg_q.tile_count <= cfg_wdata[5:0];
				tuso_pkg::REG_UPLINK_TILE_MASK:    cfg_q.uplink_tile_mask <= cfg_wdata;
				tuso_pkg::REG_DATA_SLOT_DURATION:  cfg_q.data_slot_duration <= cfg_wdata;
				tuso_pkg::REG_NODES_COUNT:         cfg_q.nodes_count <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Align engine: division, tile walk and phase reduction.
	tuso_core #(
		.MAX_TILES (MAX_TILES)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (align_start),
		.network_time (s_axis_tdata[tuso_pkg::TIME_W-1:0]),
		.cfg          (cfg_q),
		.res          (core_res)
	);

	// Sequencer, owner state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			owner_q   <= '0;
			hold_q    <= '0;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
		end else begin
			// Fill the output register, or drain it when the sink takes the item.
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_axis_tuser == tuso_pkg::OP_TAKE) begin
							// Report the owner before stepping it.
							owner_q <= take_next;
							if (out_free) begin
								m_data_q <= owner_q;
							end else begin
								hold_q  <= owner_q;
								state_q <= ST_HOLD;
							end
						end else begin
							state_q <= ST_BUSY;
						end
					end
				end
				ST_BUSY: begin
					if (core_res.done) begin
						owner_q <= core_res.owner;
						if (out_free) begin
							m_data_q <= core_res.owner;
							state_q  <= ST_IDLE;
						end else begin
							hold_q  <= core_res.owner;
							state_q <= ST_HOLD;
						end
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						m_data_q <= hold_q;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

// ===== sv/tuso_checker.sv =====
// ----------------------------------------------------------------------------
// Uplink slot owner - port checker
// Port-level properties of the owner tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "tdma_uplink_slot_owner_defines.svh"

module tuso_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata
);

	// Hold a stalled result.
	`TUSO_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result item changed or dropped")

	// Align work blocks the input side.
	`TUSO_ASSERT_NEXT(a_align_busy, clk, arst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == tuso_pkg::OP_ALIGN), !s_axis_tready, "input taken during align work")

	// Owners are never 8'hFF.
	`TUSO_ASSERT_NOW(a_node_range, clk, arst_n, m_axis_tvalid, m_axis_tdata != 8'hFF, "node out of range")

	// A fresh result comes only after an offered input item or while the input side was blocked.
	`TUSO_ASSERT_NOW(a_out_cause, clk, arst_n, $rose(m_axis_tvalid), !$past(s_axis_tready) || $past(s_axis_tvalid), "result item with no cause")

endmodule

bind tdma_uplink_slot_owner tuso_checker u_tuso_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
